@@ rtl/sacl_pkg.sv @@
// shared types and constants for the set associative cache lookup
`default_nettype none
package sacl_pkg;

  localparam int unsigned TagW  = 64;
  localparam int unsigned MaskW = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgCacheSize  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockSize  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWays       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEager      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNmru       = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic       subblock_miss;
    logic       was_write;
    logic [7:0] set_number;
  } rsp_t;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [MaskW-1:0] mask;
  } line_t;

  function automatic logic [63:0] low_ones(input logic [6:0] n);
    logic [63:0] r;
    begin
      r = (n >= 7'd64) ? '1 : ((64'd1 << n[5:0]) - 64'd1);
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/sacl_ram.sv @@
// generic single port write, single port registered read ram
`default_nettype none
module sacl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/set_assoc_cache_lookup_top.sv @@
// top level of the set associative cache lookup with lru and nmru fifo replacement
// steps per request: set read, serial scan of the ways, decide, serial write-back of each
// way, output load; a request is taken only in idle, so one request is in flight at a time
// after reset a clearing pass zeroes the line and recent-tag rams, no request is taken
// during it; a result waits in the output register while the next runs
`default_nettype none
module set_assoc_cache_lookup_top #(
  parameter int unsigned MaxSetBits = 8,
  parameter int unsigned MaxWays    = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire sacl_pkg::req_t                    in_data_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      sacl_pkg::rsp_t                    out_data_o,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [sacl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [sacl_pkg::CfgDataW-1:0]     cfg_data_i
);
  localparam int unsigned SetCount = 1 << MaxSetBits;
  localparam int unsigned WayW     = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned Lines    = SetCount * MaxWays;
  localparam int unsigned LineAW   = $clog2(Lines);
  localparam int unsigned SetAW    = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int unsigned RecDepth = (SetCount > 1) ? SetCount : 2;
  localparam int unsigned RecAW    = $clog2(RecDepth);
  localparam int unsigned WayCW    = $clog2(MaxWays + 1);

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StRead  = 7'b0000100,
    StScan  = 7'b0001000,
    StDec   = 7'b0010000,
    StWrite = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0] csize_q;
  logic [2:0] bsize_q;
  logic [1:0] ways_q;
  logic       eager_q, nmru_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csize_q <= 5'd14;
      bsize_q <= 3'd5;
      ways_q  <= 2'd2;
      eager_q <= 1'b0;
      nmru_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sacl_pkg::CfgCacheSize: csize_q <= cfg_data_i[4:0];
        sacl_pkg::CfgBlockSize: bsize_q <= cfg_data_i[2:0];
        sacl_pkg::CfgWays:      ways_q  <= cfg_data_i[1:0];
        sacl_pkg::CfgEager:     eager_q <= cfg_data_i[0];
        sacl_pkg::CfgNmru:      nmru_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // geometry
  logic [2:0]  bb;
  logic [6:0]  nsub;
  logic [4:0]  ts, sbr;
  logic [WayCW-1:0] ways_n;
  assign bb   = (bsize_q > 3'd6) ? 3'd6 : bsize_q;
  assign nsub = 7'd1 << bb;
  assign ts   = (csize_q > {3'd0, ways_q}) ? csize_q - {3'd0, ways_q} : 5'd0;
  assign sbr  = (ts > {2'd0, bb}) ? ts - {2'd0, bb} : 5'd0;
  always_comb begin
    if ((32'd1 << ways_q) > MaxWays) ways_n = WayCW'(MaxWays);
    else ways_n = WayCW'(32'd1 << ways_q);
  end

  // captured request
  logic        mode_q;
  logic [63:0] tag_q, fill_q, full_q;
  logic [5:0]  vbit_q;
  logic [SetAW-1:0] set_q;

  logic [63:0] tag_c, set_c, fill_c, full_c, off_c;
  logic [5:0]  vbit_c;
  logic [4:0]  sb_c;
  always_comb begin
    sb_c   = (sbr > 5'(MaxSetBits)) ? 5'(MaxSetBits) : sbr;
    off_c  = in_data_i.address & sacl_pkg::low_ones({4'd0, bb});
    vbit_c = (off_c < {57'd0, nsub}) ? off_c[5:0] : 6'(nsub - 7'd1);
    set_c  = (in_data_i.address >> bb) & sacl_pkg::low_ones({2'd0, sb_c});
    tag_c  = in_data_i.address >> ts;
    full_c = sacl_pkg::low_ones(nsub);
    fill_c = eager_q ? (full_c & ~sacl_pkg::low_ones({1'b0, vbit_c})) : full_c;
  end

  // scan over ways
  logic [WayCW-1:0] rd_way_q, wr_way_q;
  logic [WayCW-1:0] pos_q;
  logic found_q, hit_q, sub_q, rvalid_q;
  sacl_pkg::line_t ways_buf_q [MaxWays];
  logic [63:0] recent_q;
  logic [LineAW:0] clr_q;

  // rams
  logic line_we, rec_we;
  logic [LineAW-1:0] line_waddr, line_raddr;
  sacl_pkg::line_t line_wdata, line_rdata;
  logic [RecAW-1:0] rec_addr;
  logic [63:0] rec_wdata, rec_rdata;

  sacl_ram #(.Width($bits(sacl_pkg::line_t)), .Depth(Lines)) u_line_ram (
    .clk_i(clk_i), .we_i(line_we), .waddr_i(line_waddr), .wdata_i(line_wdata),
    .raddr_i(line_raddr), .rdata_o(line_rdata)
  );
  sacl_ram #(.Width(64), .Depth(RecDepth)) u_rec_ram (
    .clk_i(clk_i), .we_i(rec_we), .waddr_i(rec_addr), .wdata_i(rec_wdata),
    .raddr_i(rec_addr), .rdata_o(rec_rdata)
  );

  logic [LineAW-1:0] base;
  assign base = LineAW'(set_q) * LineAW'(MaxWays);

  // new contents of way w after the reorder
  logic [63:0] new_mask;
  logic [WayCW-1:0] shift_pos;
  sacl_pkg::line_t wr_line;
  always_comb begin
    new_mask  = ways_buf_q[pos_q[WayW-1:0]].mask;
    if (!found_q) new_mask = fill_q;
    else if (eager_q) new_mask = sub_q ? fill_q : new_mask;
    else if (new_mask == 64'd0) new_mask = full_q;
    shift_pos = pos_q;
    if (wr_way_q == '0) begin
      wr_line.tag  = tag_q;
      wr_line.mask = new_mask;
    end else if (wr_way_q <= shift_pos && !(found_q && nmru_q)) begin
      wr_line = ways_buf_q[WayW'(wr_way_q - 1'b1)];
    end else begin
      wr_line = ways_buf_q[wr_way_q[WayW-1:0]];
      if (found_q && nmru_q && wr_way_q == pos_q) wr_line.mask = new_mask;
    end
    if (found_q && nmru_q && wr_way_q == '0) begin
      wr_line = ways_buf_q[0];
      if (pos_q == '0) wr_line.mask = new_mask;
    end
  end

  always_comb begin
    line_we    = 1'b0;
    line_waddr = base + LineAW'(wr_way_q);
    line_wdata = wr_line;
    line_raddr = base + LineAW'(rd_way_q);
    rec_we     = 1'b0;
    rec_addr   = RecAW'(set_q);
    rec_wdata  = tag_q;
    if (state_q == StClear) begin
      line_we    = 1'b1;
      line_waddr = clr_q[LineAW-1:0];
      line_wdata = '0;
      rec_we     = 1'b1;
      rec_addr   = RecAW'(clr_q);
      rec_wdata  = '0;
    end else if (state_q == StWrite) begin
      line_we = 1'b1;
      rec_we  = nmru_q && wr_way_q == '0;
    end
  end

  sacl_pkg::rsp_t out_q;
  logic out_valid_q;
  logic out_load;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_ready_o  = (state_q == StIdle);
  assign out_load    = (state_q == StOut) && (!out_valid_q || out_ready_i);

  logic [WayCW-1:0] last_way;
  always_comb begin
    last_way = ways_n - 1'b1;
    if (nmru_q && ways_n >= 2 &&
        ways_buf_q[WayW'(ways_n - 1'b1)].tag == recent_q)
      last_way = ways_n - WayCW'(2);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_q == (LineAW+1)'(Lines - 1)) state_d = StIdle;
      StIdle:  if (in_valid_i && in_ready_o) state_d = StRead;
      StRead:  state_d = StScan;
      StScan:  if (!rvalid_q && rd_way_q == ways_n) state_d = StDec;
      StDec:   state_d = StWrite;
      StWrite: if (wr_way_q == ways_n - 1'b1) state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic match;
  sacl_pkg::line_t cur;
  logic [WayCW-1:0] cur_way;
  assign cur = line_rdata;
  assign cur_way = rd_way_q - 1'b1;
  assign match = rvalid_q && !found_q && cur.tag == tag_q &&
                 (eager_q || cur.mask != 64'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      rd_way_q    <= '0;
      wr_way_q    <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StClear: clr_q <= clr_q + 1'b1;
        StIdle: begin
          rd_way_q <= '0;
          found_q  <= 1'b0;
          rvalid_q <= 1'b0;
        end
        StRead, StScan: begin
          if (rd_way_q != ways_n) rd_way_q <= rd_way_q + 1'b1;
          rvalid_q <= rd_way_q != ways_n;
          if (match) found_q <= 1'b1;
          wr_way_q <= '0;
        end
        StWrite: wr_way_q <= wr_way_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i && in_ready_o) begin
      mode_q <= in_data_i.mode;
      tag_q  <= tag_c;
      set_q  <= SetAW'(set_c);
      fill_q <= fill_c;
      full_q <= full_c;
      vbit_q <= vbit_c;
      hit_q  <= 1'b0;
      sub_q  <= 1'b0;
    end
    if (state_q == StScan) recent_q <= rec_rdata;
    if (rvalid_q && (state_q == StScan || state_q == StRead)) begin
      ways_buf_q[cur_way[WayW-1:0]] <= cur;
      if (match) begin
        pos_q <= cur_way;
        if (!eager_q || cur.mask[vbit_q]) hit_q <= 1'b1;
        else sub_q <= 1'b1;
      end
    end
    if (state_q == StDec && !found_q) pos_q <= last_way;
    if (out_load) begin
      out_q.hit           <= hit_q;
      out_q.subblock_miss <= sub_q;
      out_q.was_write     <= mode_q;
      out_q.set_number    <= 8'(set_q);
    end
  end
endmodule
`default_nettype wire

@@ bench/set_assoc_cache_lookup_top_tb.sv @@
// testbench for the set associative cache lookup: directed and random accesses with checking
`default_nettype none
module set_assoc_cache_lookup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SetSlots = 256;
  localparam int unsigned WaySlots = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sacl_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sacl_pkg::rsp_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sacl_pkg::CfgIdxW-1:0] cfg_index_i = sacl_pkg::CfgCacheSize;
  logic [sacl_pkg::CfgDataW-1:0] cfg_data_i = '0;

  set_assoc_cache_lookup_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAIL set_assoc_cache_lookup_top");
    $finish;
  end

  // cache geometry and contents as the block should hold them
  logic [4:0] cache_log2;
  logic [2:0] line_log2;
  logic [1:0] assoc_log2;
  logic eager_on;
  logic nmru_on;
  logic [63:0] tag_mem [SetSlots*WaySlots];
  logic [63:0] valid_mem [SetSlots*WaySlots];
  logic [63:0] mru_tag [SetSlots];

  sacl_pkg::rsp_t lookup_q[$];
  int errors = 0;
  int checked = 0;
  int hits_seen = 0;
  int sub_misses_seen = 0;
  int requests_sent = 0;
  bit no_idle = 0;
  int stall_len = 0;
  int stall_cnt = 0;
  logic [63:0] addr_hist[$];

  function automatic logic [63:0] ones_below(input int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic int unsigned tag_shift();
    return (cache_log2 > assoc_log2) ? cache_log2 - assoc_log2 : 0;
  endfunction

  function automatic sacl_pkg::rsp_t predict_lookup(input sacl_pkg::req_t r);
    int unsigned bb, nways, ts, sb, off, set, base, pos, last;
    logic [63:0] tag, full, fill, m;
    bit found, hit, smiss;
    sacl_pkg::rsp_t res;
    bb = (line_log2 > 6) ? 6 : line_log2;
    nways = 1 << assoc_log2;
    ts = tag_shift();
    sb = (ts > bb) ? ts - bb : 0;
    if (sb > 8) sb = 8;
    off = 32'(r.address & ones_below(bb));
    set = 32'((r.address >> bb) & ones_below(sb));
    tag = r.address >> ts;
    base = set * WaySlots;
    full = ones_below(1 << bb);
    fill = eager_on ? (full & ~ones_below(off)) : full;
    found = 0; hit = 0; smiss = 0; pos = 0;
    for (int j = 0; j < nways; j++) begin
      if (!found && tag_mem[base+j] == tag) begin
        if (eager_on) begin
          found = 1;
          pos = j;
          if (valid_mem[base+j][off]) hit = 1;
          else begin
            smiss = 1;
            valid_mem[base+j] = fill;
          end
        end else if (valid_mem[base+j] != 0) begin
          found = 1;
          hit = 1;
          pos = j;
        end
      end
    end
    if (found) begin
      if (nmru_on) mru_tag[set] = tag;
      else begin
        m = valid_mem[base+pos];
        if (!eager_on && m == 0) m = full;
        for (int j = pos; j > 0; j--) begin
          tag_mem[base+j] = tag_mem[base+j-1];
          valid_mem[base+j] = valid_mem[base+j-1];
        end
        tag_mem[base] = tag;
        valid_mem[base] = m;
      end
    end else begin
      last = nways - 1;
      if (nmru_on && nways >= 2 && tag_mem[base+last] == mru_tag[set]) last = nways - 2;
      for (int j = last; j > 0; j--) begin
        tag_mem[base+j] = tag_mem[base+j-1];
        valid_mem[base+j] = valid_mem[base+j-1];
      end
      tag_mem[base] = tag;
      valid_mem[base] = fill;
      if (nmru_on) mru_tag[set] = tag;
    end
    res.hit = hit;
    res.subblock_miss = smiss;
    res.was_write = r.mode;
    res.set_number = set[7:0];
    return res;
  endfunction

  // response side: random stalls plus an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt <= 0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (stall_len > 0) begin
      stall_cnt <= stall_len;
      stall_len = 0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= 13);
    end
  end

  // outputs move only on the rising edge, so the falling edge sees the coming handshake
  always @(negedge clk_i) begin
    sacl_pkg::rsp_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lookup_q.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        errors++;
      end else begin
        exp_r = lookup_q.pop_front();
        checked++;
        if (exp_r.hit) hits_seen++;
        if (exp_r.subblock_miss) sub_misses_seen++;
        if (out_data_o.hit !== exp_r.hit) begin
          $error("hit expected %0d actual %0d", exp_r.hit, out_data_o.hit);
          errors++;
        end
        if (out_data_o.subblock_miss !== exp_r.subblock_miss) begin
          $error("subblock_miss expected %0d actual %0d",
                 exp_r.subblock_miss, out_data_o.subblock_miss);
          errors++;
        end
        if (out_data_o.was_write !== exp_r.was_write) begin
          $error("was_write expected %0d actual %0d", exp_r.was_write, out_data_o.was_write);
          errors++;
        end
        if (out_data_o.set_number !== exp_r.set_number) begin
          $error("set_number expected %0d actual %0d",
                 exp_r.set_number, out_data_o.set_number);
          errors++;
        end
      end
    end
  end

  task automatic send_request(input logic mode, input logic [63:0] addr);
    sacl_pkg::req_t r;
    bit rdy;
    // an all-zero tag could match a line that was never filled
    if ((addr >> tag_shift()) == 0) addr[63] = ~addr[63];
    r.mode = mode;
    r.address = addr;
    if (!no_idle && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    lookup_q.push_back(predict_lookup(r));
    requests_sent++;
    addr_hist.push_back(addr);
    if (addr_hist.size() > 24) void'(addr_hist.pop_front());
  endtask

  task automatic drain();
    int guard = 0;
    in_valid_i <= 1'b0;
    while (lookup_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [sacl_pkg::CfgIdxW-1:0] idx,
                           input logic [sacl_pkg::CfgDataW-1:0] val);
    bit rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    case (idx)
      sacl_pkg::CfgCacheSize: cache_log2 = val[4:0];
      sacl_pkg::CfgBlockSize: line_log2 = val[2:0];
      sacl_pkg::CfgWays:      assoc_log2 = val[1:0];
      sacl_pkg::CfgEager:     eager_on = val[0];
      sacl_pkg::CfgNmru:      nmru_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int cs, input int bs, input int wl, input int eg,
                              input int nm);
    drain();
    write_reg(sacl_pkg::CfgCacheSize, sacl_pkg::CfgDataW'(cs));
    write_reg(sacl_pkg::CfgBlockSize, sacl_pkg::CfgDataW'(bs));
    write_reg(sacl_pkg::CfgWays, sacl_pkg::CfgDataW'(wl));
    write_reg(sacl_pkg::CfgEager, sacl_pkg::CfgDataW'(eg));
    write_reg(sacl_pkg::CfgNmru, sacl_pkg::CfgDataW'(nm));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] pick_address();
    int unsigned k = $urandom_range(99);
    logic [63:0] a;
    if (k < 45 && addr_hist.size() > 0) begin
      a = addr_hist[$urandom_range(addr_hist.size() - 1)];
      if ($urandom_range(1)) a[5:0] = 6'($urandom);
    end else if (k < 85) begin
      a = {$urandom, $urandom} & ones_below(tag_shift());
      a |= 64'($urandom_range(1, 12)) << tag_shift();
    end else begin
      a = {$urandom, $urandom};
    end
    return a;
  endfunction

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++) send_request(1'($urandom_range(1)), pick_address());
  endtask

  task automatic test_defaults_directed();
    send_request(1'b0, 64'h0000_0000_0001_0000);
    send_request(1'b1, 64'h0000_0000_0001_0000);
    send_request(1'b0, '1);
    send_request(1'b1, 64'h8000_0000_0000_0000);
    send_request(1'b0, 64'h0000_0000_0000_3fe0);
    for (int t = 1; t <= 6; t++) send_request(t[0], 64'(t) << 12);
    send_request(1'b0, 64'h0000_0000_0000_1000);
  endtask

  task automatic test_geometry_extremes();
    set_geometry(0, 0, 0, 0, 0);
    send_request(1'b0, 64'h5);
    send_request(1'b1, 64'h5);
    send_request(1'b0, 64'h6);
    set_geometry(17, 6, 3, 0, 0);
    send_request(1'b0, 64'h0002_0000);
    send_request(1'b1, 64'h0001_ffff);
    set_geometry(31, 7, 3, 1, 0);
    send_request(1'b0, 64'h0000_0001_0000_0001);
    set_geometry(2, 3, 3, 0, 1);
    send_request(1'b1, 64'h3);
    send_request(1'b0, 64'h3);
  endtask

  task automatic test_eager_subblocks();
    set_geometry(10, 4, 1, 1, 0);
    send_request(1'b0, 64'h0000_4008);
    send_request(1'b0, 64'h0000_400c);
    send_request(1'b0, 64'h0000_4002);
    send_request(1'b1, 64'h0000_4002);
    random_burst(30);
  endtask

  task automatic test_nmru_spare();
    set_geometry(9, 3, 2, 0, 1);
    for (int t = 1; t <= 6; t++) send_request(1'b0, 64'(t) << 7);
    send_request(1'b0, 64'h1 << 7);
    random_burst(30);
    set_geometry(9, 3, 0, 1, 1);
    random_burst(20);
  endtask

  task automatic test_backpressure();
    set_geometry(14, 5, 2, 0, 0);
    drain();
    no_idle = 1;
    stall_len = 300;
    random_burst(40);
    drain();
    no_idle = 0;
  endtask

  task automatic test_random_sweep();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 5) no_idle = 1;
      if (ph == 7) no_idle = 0;
      set_geometry($urandom_range(17), $urandom_range(7), $urandom_range(3),
                   $urandom_range(1), $urandom_range(1));
      random_burst(50);
    end
  endtask

  initial begin
    cache_log2 = 14;
    line_log2 = 5;
    assoc_log2 = 2;
    eager_on = 0;
    nmru_on = 0;
    foreach (tag_mem[i]) begin
      tag_mem[i] = '0;
      valid_mem[i] = '0;
    end
    foreach (mru_tag[i]) mru_tag[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults_directed();
    test_geometry_extremes();
    test_eager_subblocks();
    test_nmru_spare();
    test_backpressure();
    test_random_sweep();
    drain();
    $display("covered %0d requests, %0d results checked, %0d hits, %0d sub-block misses",
             requests_sent, checked, hits_seen, sub_misses_seen);
    $display("geometries swept from single-byte lines to oversized caches, lru and nmru");
    if (errors == 0 && lookup_q.size() == 0) begin
      $display("PASS set_assoc_cache_lookup_top");
    end else begin
      $display("FAIL set_assoc_cache_lookup_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
